[sv/srbs_pkg.sv]
// ----------------------------------------------------------------------------
// srbs_pkg: shared widths and field positions
// Fixed field widths of the bucket statistics stream and the layout of the
// result beat.
// ----------------------------------------------------------------------------
package srbs_pkg;

  localparam int VALUE_W = 32;  // unsigned Q16.16 value
  localparam int RANGE_W = 33;  // signed Q16.16 difference
  localparam int IDX_W   = 7;   // bucket number as output
  localparam int CFG_W   = 17;  // row length register

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

  // result tdata layout, lowest bit first
  localparam int MEAN_LSB    = IDX_W;
  localparam int RANGE_LSB   = MEAN_LSB + VALUE_W;
  localparam int MSTEP_LSB   = RANGE_LSB + RANGE_W;
  localparam int MAX_LSB     = MSTEP_LSB + RANGE_W;
  localparam int OUT_FIELD_W = MAX_LSB + VALUE_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

endpackage

[sv/srbs_front.sv]
// ----------------------------------------------------------------------------
// srbs_front: bucket accumulator
// Derives bucket sizes from the row length, takes one value per beat and
// emits one record per finished bucket.
// ----------------------------------------------------------------------------
module srbs_front
  import srbs_pkg::*;
#(
  parameter int BUCKETS = 128,
  parameter int MAX_ROW = 65536,
  parameter int LEN_W   = 17,
  parameter int SIZE_W  = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [VALUE_W-1:0]       in_tdata,
  input  logic                     push_ready,
  output logic                     push,
  output logic [IDX_W-1:0]         rec_idx,
  output logic [VALUE_W+SIZE_W-1:0] rec_sum,
  output logic [RANGE_W-1:0]       rec_range,
  output logic [VALUE_W-1:0]       rec_max,
  output logic [SIZE_W-1:0]        rec_size,
  output logic                     rec_last
);

  localparam int CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int BIDX_W = $clog2(BUCKETS);
  localparam int SUM_W  = VALUE_W + SIZE_W;

  // reciprocal of BUCKETS, exact for every length below 2**LEN_W
  localparam int RECIP_S = LEN_W + BIDX_W;
  localparam int RECIP_W = LEN_W + 2;
  localparam int PROD_W  = LEN_W + RECIP_W;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_S) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] len);
    logic [CMP_W-1:0] l;
    l = CMP_W'(len);
    if (l > CMP_W'(MAX_ROW)) l = CMP_W'(MAX_ROW);
    if (l < CMP_W'(BUCKETS)) l = CMP_W'(BUCKETS);
    return LEN_W'(l);
  endfunction

  // size derivation: quotient by reciprocal multiply, then the remainder
  logic               div_busy_r;
  logic               div_phase_r;
  logic [LEN_W-1:0]   div_num_r;
  logic [SIZE_W-1:0]  base_r;
  logic [BIDX_W-1:0]  extra_r;

  logic [PROD_W-1:0]  quot_prod;
  logic [LEN_W-1:0]   rem_full;

  assign quot_prod = PROD_W'(div_num_r) * PROD_W'(RECIP);
  assign rem_full  = div_num_r - LEN_W'(base_r) * LEN_W'(BUCKETS);

  // accumulators
  logic [BIDX_W-1:0]  cur_r, cur_nxt;
  logic [SIZE_W-1:0]  pos_r, pos_nxt;
  logic [VALUE_W-1:0] first_r, first_nxt;
  logic [VALUE_W-1:0] prev_r;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [VALUE_W-1:0] max_r, max_nxt;

  logic               accept;
  logic [RANGE_W-1:0] step;
  logic [SIZE_W-1:0]  size;
  logic [SIZE_W-1:0]  pos_inc;
  logic               bucket_close;
  logic               last_bucket;

  assign cfg_ready    = 1'b1;
  assign in_tready    = !div_busy_r && push_ready;
  assign accept       = in_tvalid && in_tready;
  assign step         = {1'b0, in_tdata} - {1'b0, prev_r};
  assign size         = base_r + SIZE_W'(cur_r < extra_r);
  assign pos_inc      = pos_r + SIZE_W'(1);
  assign bucket_close = pos_inc == size;
  assign last_bucket  = cur_r == BIDX_W'(BUCKETS - 1);

  always_comb begin
    if (pos_r == '0) begin
      first_nxt = in_tdata;
      sum_nxt   = SUM_W'(in_tdata);
      max_nxt   = '0;
    end else begin
      first_nxt = first_r;
      sum_nxt   = sum_r + SUM_W'(in_tdata);
      max_nxt   = (!step[RANGE_W-1] && step[VALUE_W-1:0] > max_r) ?
                  step[VALUE_W-1:0] : max_r;
    end
    if (bucket_close) begin
      pos_nxt = '0;
      cur_nxt = last_bucket ? '0 : cur_r + BIDX_W'(1);
    end else begin
      pos_nxt = pos_inc;
      cur_nxt = cur_r;
    end
  end

  assign push      = accept && bucket_close;
  assign rec_idx   = IDX_W'(cur_r);
  assign rec_sum   = sum_nxt;
  assign rec_range = {1'b0, in_tdata} - {1'b0, first_nxt};
  assign rec_max   = max_nxt;
  assign rec_size  = size;
  assign rec_last  = last_bucket;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r  <= 1'b1;
      div_phase_r <= 1'b0;
      div_num_r   <= eff_len(CFG_RESET);
      cur_r       <= '0;
      pos_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      // new length: rederive sizes and restart the row
      div_busy_r  <= 1'b1;
      div_phase_r <= 1'b0;
      div_num_r   <= eff_len(cfg_data);
      cur_r       <= '0;
      pos_r       <= '0;
    end else begin
      if (div_busy_r) begin
        if (!div_phase_r) begin
          base_r      <= quot_prod[RECIP_S +: SIZE_W];
          div_phase_r <= 1'b1;
        end else begin
          extra_r    <= BIDX_W'(rem_full);
          div_busy_r <= 1'b0;
        end
      end
      if (accept) begin
        cur_r <= cur_nxt;
        pos_r <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_r <= first_nxt;
      prev_r  <= in_tdata;
      sum_r   <= sum_nxt;
      max_r   <= max_nxt;
    end
  end

endmodule

[sv/srbs_queue.sv]
// ----------------------------------------------------------------------------
// srbs_queue: record queue
// Short register queue between accumulator and divider back end.
// ----------------------------------------------------------------------------
module srbs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/srbs_back.sv]
// ----------------------------------------------------------------------------
// srbs_back: bucket divider back end
// Two restoring dividers in lockstep give mean value and mean step; the
// result is held in the output register until taken.
// ----------------------------------------------------------------------------
module srbs_back
  import srbs_pkg::*;
#(
  parameter int SIZE_W = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  logic [IDX_W-1:0]          rec_idx,
  input  logic [VALUE_W+SIZE_W-1:0] rec_sum,
  input  logic [RANGE_W-1:0]        rec_range,
  input  logic [VALUE_W-1:0]        rec_max,
  input  logic [SIZE_W-1:0]         rec_size,
  input  logic                      rec_last,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_DATA_W-1:0]     out_tdata,
  output logic                      out_tuser,
  output logic                      out_tlast
);

  localparam int SUM_W = VALUE_W + SIZE_W;
  localparam int CNT_W = $clog2(SUM_W);
  localparam int PAD_W = OUT_DATA_W - OUT_FIELD_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    num_a_r, num_b_r;
  logic [SIZE_W-1:0]   rem_a_r, rem_b_r;
  logic [SIZE_W-1:0]   den_a_r, den_b_r;
  logic [IDX_W-1:0]    idx_r;
  logic [RANGE_W-1:0]  range_r;
  logic [VALUE_W-1:0]  max_r;
  logic                neg_r, single_r, last_r;
  logic                out_tvalid_r, out_tuser_r, out_tlast_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  // one quotient bit per cycle for each divider
  logic [SIZE_W:0]     sh_a, sh_b;
  logic                ge_a, ge_b;
  logic [SIZE_W:0]     sub_a, sub_b;
  logic [RANGE_W-1:0]  range_mag;
  logic [RANGE_W-1:0]  mstep;
  logic                load_out;

  assign sh_a  = {rem_a_r, num_a_r[SUM_W-1]};
  assign sh_b  = {rem_b_r, num_b_r[SUM_W-1]};
  assign ge_a  = sh_a >= {1'b0, den_a_r};
  assign ge_b  = sh_b >= {1'b0, den_b_r};
  assign sub_a = ge_a ? sh_a - {1'b0, den_a_r} : sh_a;
  assign sub_b = ge_b ? sh_b - {1'b0, den_b_r} : sh_b;

  assign range_mag = rec_range[RANGE_W-1] ? ~rec_range + RANGE_W'(1) : rec_range;

  always_comb begin
    if (single_r) begin
      mstep = '0;
    end else if (neg_r) begin
      mstep = ~{1'b0, num_b_r[VALUE_W-1:0]} + RANGE_W'(1);
    end else begin
      mstep = {1'b0, num_b_r[VALUE_W-1:0]};
    end
  end

  // load the output register once it is free or being taken
  assign load_out   = (state_r == ST_HOLD) && (!out_tvalid_r || out_tready);
  assign q_pop      = (state_r == ST_IDLE) && q_valid;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            num_a_r  <= rec_sum;
            num_b_r  <= SUM_W'(range_mag[VALUE_W-1:0]);
            rem_a_r  <= '0;
            rem_b_r  <= '0;
            den_a_r  <= rec_size;
            den_b_r  <= rec_size - SIZE_W'(1);
            idx_r    <= rec_idx;
            range_r  <= rec_range;
            max_r    <= rec_max;
            neg_r    <= rec_range[RANGE_W-1];
            single_r <= rec_size == SIZE_W'(1);
            last_r   <= rec_last;
            cnt_r    <= '0;
            state_r  <= ST_DIV;
          end
        end
        ST_DIV: begin
          num_a_r <= {num_a_r[SUM_W-2:0], ge_a};
          num_b_r <= {num_b_r[SUM_W-2:0], ge_b};
          rem_a_r <= SIZE_W'(sub_a);
          rem_b_r <= SIZE_W'(sub_b);
          cnt_r   <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(SUM_W - 1)) begin
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          // wait for a free output register
          if (load_out) begin
            out_tdata_r  <= {{PAD_W{1'b0}}, max_r, mstep, range_r,
                             num_a_r[VALUE_W-1:0], idx_r};
            out_tuser_r  <= single_r;
            out_tlast_r  <= last_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/sorted_row_bucket_statistics.sv]
// ----------------------------------------------------------------------------
// sorted_row_bucket_statistics: per-bucket statistics of a sorted row
// Splits each row of distances into BUCKETS buckets and reports mean, range,
// mean step and largest step for every bucket.
// ----------------------------------------------------------------------------
// Values of a row stream in one per beat, in order, and rows follow back to
// back. A row of row_length values (clamped to BUCKETS..MAX_ROW) is cut into
// BUCKETS buckets of row_length / BUCKETS values; the first
// row_length % BUCKETS buckets take one value more. One result beat leaves
// at the end of each bucket; tlast marks the last bucket of a row and tuser
// flags a single-value bucket, whose mean step reads as zero.
// Flow: the front end takes one value per cycle while in_tready is high.
// Each bucket then occupies the back-end divider, which computes both means
// one quotient bit a cycle and takes no new bucket until the last has left
// ST_HOLD. Buckets at least as long as the divider's work per bucket stream
// at one value per cycle; with shorter buckets the divider sets the pace
// and the four-entry record queue fills until in_tready drops. After reset
// and after every row_length write the block derives the bucket sizes with
// a reciprocal multiply and a remainder step and holds in_tready low
// meanwhile. A row_length write restarts the row at bucket 0.
// ----------------------------------------------------------------------------
module sorted_row_bucket_statistics
  import srbs_pkg::*;
#(
  parameter int BUCKETS = 128,
  parameter int MAX_ROW = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // row length register
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data,
  // sorted values
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VALUE_W-1:0]    in_tdata,    // [31:0] dist_value
  // bucket results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [6:0] bucket_index, [38:7]
                                             // mean_value, [71:39]
                                             // value_range, [104:72]
                                             // mean_step, [136:105]
                                             // max_step, rest zero
  output logic                  out_tuser,   // [0] step_undefined
  output logic                  out_tlast    // row_done
);

  localparam int LMAX   = (MAX_ROW > BUCKETS) ? MAX_ROW : BUCKETS;
  localparam int LEN_W  = $clog2(LMAX + 1);
  localparam int SIZE_W = $clog2(LMAX / BUCKETS + 2);
  localparam int SUM_W  = VALUE_W + SIZE_W;
  localparam int REC_W  = IDX_W + SUM_W + RANGE_W + VALUE_W + SIZE_W + 1;
  localparam int Q_DEPTH = 4;

  // front end record
  logic                push, push_ready;
  logic [IDX_W-1:0]    f_idx;
  logic [SUM_W-1:0]    f_sum;
  logic [RANGE_W-1:0]  f_range;
  logic [VALUE_W-1:0]  f_max;
  logic [SIZE_W-1:0]   f_size;
  logic                f_last;

  // back end record
  logic                q_valid, q_pop;
  logic [REC_W-1:0]    q_data;
  logic [IDX_W-1:0]    b_idx;
  logic [SUM_W-1:0]    b_sum;
  logic [RANGE_W-1:0]  b_range;
  logic [VALUE_W-1:0]  b_max;
  logic [SIZE_W-1:0]   b_size;
  logic                b_last;

  srbs_front #(
    .BUCKETS (BUCKETS),
    .MAX_ROW (MAX_ROW),
    .LEN_W   (LEN_W),
    .SIZE_W  (SIZE_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_ready (push_ready),
    .push       (push),
    .rec_idx    (f_idx),
    .rec_sum    (f_sum),
    .rec_range  (f_range),
    .rec_max    (f_max),
    .rec_size   (f_size),
    .rec_last   (f_last)
  );

  srbs_queue #(
    .WIDTH (REC_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({f_last, f_size, f_max, f_range, f_sum, f_idx}),
    .push_ready (push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  assign {b_last, b_size, b_max, b_range, b_sum, b_idx} = q_data;

  srbs_back #(
    .SIZE_W (SIZE_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .rec_idx    (b_idx),
    .rec_sum    (b_sum),
    .rec_range  (b_range),
    .rec_max    (b_max),
    .rec_size   (b_size),
    .rec_last   (b_last),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // a single-value bucket has no spread and no step
  a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[MSTEP_LSB +: RANGE_W] == '0 && out_tdata[RANGE_LSB +: RANGE_W] == '0 &&
      out_tdata[MAX_LSB +: VALUE_W] == '0)
    else $error("single-value bucket with nonzero step fields");

  // end of row only on the last bucket
  a_row_done_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[IDX_W-1:0] == IDX_W'(BUCKETS - 1))
    else $error("row_done on a bucket other than the last");

  // a length write blocks input while sizes are rederived
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_tready)
    else $error("input accepted right after a length write");

endmodule
